>>> sv/heartbeat_lockup_watchdog_defines.svh
// ----------------------------------------------------------------------------
// Heartbeat lockup watchdog assertion macros
// Shared concurrent assertion forms for the watchdog checker.
// ----------------------------------------------------------------------------
`ifndef HEARTBEAT_LOCKUP_WATCHDOG_DEFINES_SVH
`define HEARTBEAT_LOCKUP_WATCHDOG_DEFINES_SVH

// Same-cycle implication, off during reset.
`define HLW_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("watchdog check failed: same-cycle implication");

// Next-cycle implication, off during reset.
`define HLW_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("watchdog check failed: next-cycle implication");

`endif

>>> sv/hlw_pkg.sv
// ----------------------------------------------------------------------------
// Heartbeat lockup watchdog package
// Widths, register indexes, command codes and shared structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hlw_pkg;

  localparam int TIME_BITS  = 32;
  localparam int TRIG_BITS  = 16;
  localparam int COUNT_BITS = TRIG_BITS + 1;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;

  typedef logic [TIME_BITS-1:0]  time_t;
  typedef logic [TRIG_BITS-1:0]  trig_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_POLL_INTERVAL      = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_EDGE_COUNT_TRIGGER = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COOLDOWN_TIME      = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LOCKUP_TIME        = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RECOVERY_ENABLE    = 3'd4;

  // Register reset values
  localparam time_t RST_POLL_INTERVAL      = time_t'(1000);
  localparam trig_t RST_EDGE_COUNT_TRIGGER = trig_t'(10);
  localparam time_t RST_COOLDOWN_TIME      = time_t'(60000);
  localparam time_t RST_LOCKUP_TIME        = time_t'(30000);
  localparam logic  RST_RECOVERY_ENABLE    = 1'b1;

  // Command codes
  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef struct packed {
    time_t poll_interval;
    trig_t edge_count_trigger;
    time_t cooldown_time;
    time_t lockup_time;
    logic  recovery_enable;
  } cfg_t;

  typedef struct packed {
    logic  cmd;
    time_t now_ms;
    logic  heartbeat_level;
    logic  power_good;
  } item_t;

  typedef struct packed {
    logic polled;
    logic lockup_seen;
    logic recovery_request;
    logic in_cooldown;
  } result_t;

endpackage

>>> sv/hlw_core.sv
// ----------------------------------------------------------------------------
// Heartbeat lockup watchdog core
// Watch state and the combinational update for one start or sample item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hlw_core
  import hlw_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    fire,
  input  item_t   item,
  output result_t res
);

  time_t  next_poll_time, next_poll_time_next;
  time_t  last_edge_time, last_edge_time_next;
  logic   last_heartbeat, last_heartbeat_next;
  count_t edge_count, edge_count_next;
  time_t  cooldown_end, cooldown_end_next;

  count_t trig_ext;
  logic   due;
  logic   hb_edge;
  logic   stale;
  logic   cooling;

  always_comb begin
    trig_ext = count_t'(cfg.edge_count_trigger);
    due      = item.now_ms > next_poll_time;
    hb_edge  = item.heartbeat_level != last_heartbeat;
    stale    = item.now_ms > time_t'(last_edge_time + cfg.lockup_time);
    cooling  = item.now_ms < cooldown_end;

    next_poll_time_next = next_poll_time;
    last_edge_time_next = last_edge_time;
    last_heartbeat_next = last_heartbeat;
    edge_count_next     = edge_count;
    cooldown_end_next   = cooldown_end;
    res.polled           = 1'b0;
    res.lockup_seen      = 1'b0;
    res.recovery_request = 1'b0;

    if (item.cmd == CMD_START) begin
      next_poll_time_next = time_t'(item.now_ms + cfg.poll_interval);
      last_edge_time_next = '0;
      last_heartbeat_next = 1'b0;
      edge_count_next     = '0;
      // Start cooldown end is the register value taken as an absolute time
      cooldown_end_next   = cfg.cooldown_time;
    end else if (due) begin
      res.polled          = 1'b1;
      next_poll_time_next = time_t'(next_poll_time + cfg.poll_interval);
      if (hb_edge) begin
        last_heartbeat_next = item.heartbeat_level;
        last_edge_time_next = item.now_ms;
        if (edge_count < trig_ext) begin
          edge_count_next = count_t'(edge_count + 1'b1);
        end else if (edge_count == trig_ext) begin
          // Enough edges: end cooldown now, then saturate the count
          cooldown_end_next = item.now_ms;
          edge_count_next   = count_t'(edge_count + 1'b1);
        end
      end else if ((stale && !cooling) || !item.power_good) begin
        res.lockup_seen      = 1'b1;
        res.recovery_request = cfg.recovery_enable;
        edge_count_next      = '0;
        last_edge_time_next  = item.now_ms;
        cooldown_end_next    = time_t'(item.now_ms + cfg.cooldown_time);
      end
    end

    res.in_cooldown = item.now_ms < cooldown_end_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_poll_time <= '0;
      last_edge_time <= '0;
      last_heartbeat <= 1'b0;
      edge_count     <= '0;
      cooldown_end   <= '0;
    end else if (fire) begin
      next_poll_time <= next_poll_time_next;
      last_edge_time <= last_edge_time_next;
      last_heartbeat <= last_heartbeat_next;
      edge_count     <= edge_count_next;
      cooldown_end   <= cooldown_end_next;
    end
  end

endmodule

>>> sv/heartbeat_lockup_watchdog.sv
// ----------------------------------------------------------------------------
// Heartbeat lockup watchdog
// Host heartbeat and power-good monitor with lockup detection.
// ----------------------------------------------------------------------------
// One item per clock sustained while the output is not stalled. An item is
// captured in an input register; the core updates the watch state and the
// result as the item moves on, once the output register is free, and the
// result waits in the output register. The input side stalls only when
// both registers are full and the output is stalled. Configuration writes
// are always ready and take effect at once; write them while idle.
`timescale 1ns / 1ps

module heartbeat_lockup_watchdog
  import hlw_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     cmd,
  input  logic [TIME_BITS-1:0]     now_ms,
  input  logic                     heartbeat_level,
  input  logic                     power_good,
  // output channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     polled,
  output logic                     lockup_seen,
  output logic                     recovery_request,
  output logic                     in_cooldown,
  // configuration write channel
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  cfg_t    cfg;
  logic    s1_valid, s1_valid_next;
  item_t   s1_item;
  logic    out_valid_next;
  result_t out_res;
  result_t core_res;
  logic    in_take;
  logic    advance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.poll_interval      <= RST_POLL_INTERVAL;
      cfg.edge_count_trigger <= RST_EDGE_COUNT_TRIGGER;
      cfg.cooldown_time      <= RST_COOLDOWN_TIME;
      cfg.lockup_time        <= RST_LOCKUP_TIME;
      cfg.recovery_enable    <= RST_RECOVERY_ENABLE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_POLL_INTERVAL:      cfg.poll_interval      <= time_t'(cfg_data);
        CFG_EDGE_COUNT_TRIGGER: cfg.edge_count_trigger <= cfg_data[TRIG_BITS-1:0];
        CFG_COOLDOWN_TIME:      cfg.cooldown_time      <= time_t'(cfg_data);
        CFG_LOCKUP_TIME:        cfg.lockup_time        <= time_t'(cfg_data);
        CFG_RECOVERY_ENABLE:    cfg.recovery_enable    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Move the held item into the core when the output register frees up
  always_comb begin
    advance  = s1_valid && (!out_valid || !out_stall);
    in_stall = s1_valid && !advance;
    in_take  = in_valid && !in_stall;

    s1_valid_next = s1_valid;
    if (in_take) begin
      s1_valid_next = 1'b1;
    end else if (advance) begin
      s1_valid_next = 1'b0;
    end

    out_valid_next = out_valid;
    if (advance) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= s1_valid_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item.cmd             <= cmd;
      s1_item.now_ms          <= now_ms;
      s1_item.heartbeat_level <= heartbeat_level;
      s1_item.power_good      <= power_good;
    end
    if (advance) begin
      out_res <= core_res;
    end
  end

  hlw_core u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .fire (advance),
    .item (s1_item),
    .res  (core_res)
  );

  assign polled           = out_res.polled;
  assign lockup_seen      = out_res.lockup_seen;
  assign recovery_request = out_res.recovery_request;
  assign in_cooldown      = out_res.in_cooldown;

endmodule

>>> sv/hlw_checker.sv
// ----------------------------------------------------------------------------
// Heartbeat lockup watchdog checker
// Port-level assertions on result consistency and output holding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "heartbeat_lockup_watchdog_defines.svh"

module hlw_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_stall,
  input logic polled,
  input logic lockup_seen,
  input logic recovery_request
);

  // A stalled result stays offered
  `HLW_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)
  // Recovery is only requested together with a detected lockup
  `HLW_ASSERT_NOW(a_rec_lock, clk, rst, out_valid && recovery_request, lockup_seen)
  // Lockup is only detected on an evaluated sample
  `HLW_ASSERT_NOW(a_lock_polled, clk, rst, out_valid && lockup_seen, polled)

endmodule

bind heartbeat_lockup_watchdog hlw_checker u_hlw_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .polled           (polled),
  .lockup_seen      (lockup_seen),
  .recovery_request (recovery_request)
);

>>> test/heartbeat_lockup_watchdog_tb.sv
// ----------------------------------------------------------------------------
// Heartbeat lockup watchdog testbench
// Runs the watchdog through directed and randomized sessions under several
// register settings, while both channels idle at random. A local model of the
// watch state predicts every result, and the monitor checks each one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module heartbeat_lockup_watchdog_tb;
  import hlw_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SQUEEZE_CYCLES = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     cmd = CMD_START;
  logic [TIME_BITS-1:0]     now_ms = '0;
  logic                     heartbeat_level = 1'b0;
  logic                     power_good = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     polled;
  logic                     lockup_seen;
  logic                     recovery_request;
  logic                     in_cooldown;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = CFG_POLL_INTERVAL;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  heartbeat_lockup_watchdog dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .cmd              (cmd),
    .now_ms           (now_ms),
    .heartbeat_level  (heartbeat_level),
    .power_good       (power_good),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .polled           (polled),
    .lockup_seen      (lockup_seen),
    .recovery_request (recovery_request),
    .in_cooldown      (in_cooldown),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Register settings currently in the block
  cfg_t live_cfg;

  // Local copy of the watch state
  time_t  wd_next_poll;
  time_t  wd_last_edge;
  time_t  wd_cool_end;
  logic   wd_last_hb;
  count_t wd_edges;

  item_t   pending_samples[$];
  result_t awaited_results[$];
  item_t   cur_item;
  int      fail_count = 0;
  int      tick_count = 0;
  int      squeeze_req = 0;
  int      squeeze_seen = 0;
  int      send_gap = 0;
  int      send_calm = 0;
  int      recv_hold = 0;
  int      recv_calm = 0;

  function automatic result_t watch_step(input item_t it);
    result_t r;
    time_t   stale_at;
    logic    stale;
    logic    cooling;
    r = '0;
    if (it.cmd == CMD_START) begin
      wd_next_poll = it.now_ms + live_cfg.poll_interval;
      wd_last_edge = '0;
      wd_last_hb   = 1'b0;
      wd_edges     = '0;
      // cooldown end after start is absolute, not relative to now
      wd_cool_end  = live_cfg.cooldown_time;
    end else if (it.now_ms > wd_next_poll) begin
      r.polled = 1'b1;
      wd_next_poll = wd_next_poll + live_cfg.poll_interval;
      if (it.heartbeat_level != wd_last_hb) begin
        wd_last_hb   = it.heartbeat_level;
        wd_last_edge = it.now_ms;
        if (wd_edges < live_cfg.edge_count_trigger) begin
          wd_edges = wd_edges + 1'b1;
        end else if (wd_edges == live_cfg.edge_count_trigger) begin
          wd_cool_end = it.now_ms;
          wd_edges = wd_edges + 1'b1;
        end
      end else begin
        stale_at = wd_last_edge + live_cfg.lockup_time;
        stale    = it.now_ms > stale_at;
        cooling  = it.now_ms < wd_cool_end;
        if ((stale && !cooling) || !it.power_good) begin
          r.lockup_seen      = 1'b1;
          r.recovery_request = live_cfg.recovery_enable;
          wd_edges     = '0;
          wd_last_edge = it.now_ms;
          wd_cool_end  = it.now_ms + live_cfg.cooldown_time;
        end
      end
    end
    r.in_cooldown = it.now_ms < wd_cool_end;
    return r;
  endfunction

  // Idle stretch length: mostly short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Sender: offer queued samples, hold each until taken
  always @(posedge clk) begin
    if (rst) begin
      in_valid     <= 1'b0;
      wd_next_poll = '0;
      wd_last_edge = '0;
      wd_cool_end  = '0;
      wd_last_hb   = 1'b0;
      wd_edges     = '0;
    end else begin
      if (in_valid && !in_stall) awaited_results.push_back(watch_step(cur_item));
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          cur_item = pending_samples.pop_front();
          in_valid        <= 1'b1;
          cmd             <= cur_item.cmd;
          now_ms          <= cur_item.now_ms;
          heartbeat_level <= cur_item.heartbeat_level;
          power_good      <= cur_item.power_good;
          if (send_calm > 0) begin
            send_calm--;
          end else if ($urandom_range(0, 39) == 0) begin
            send_calm = $urandom_range(20, 80);
          end else if ($urandom_range(0, 99) >= 55) begin
            send_gap = idle_len();
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result transaction and drive stall
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result: polled=%0b lockup_seen=%0b recovery_request=%0b in_cooldown=%0b",
                 polled, lockup_seen, recovery_request, in_cooldown);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          if (polled !== want.polled) begin
            $error("polled: expected %0b, actual %0b", want.polled, polled);
            fail_count++;
          end
          if (lockup_seen !== want.lockup_seen) begin
            $error("lockup_seen: expected %0b, actual %0b", want.lockup_seen, lockup_seen);
            fail_count++;
          end
          if (recovery_request !== want.recovery_request) begin
            $error("recovery_request: expected %0b, actual %0b",
                   want.recovery_request, recovery_request);
            fail_count++;
          end
          if (in_cooldown !== want.in_cooldown) begin
            $error("in_cooldown: expected %0b, actual %0b", want.in_cooldown, in_cooldown);
            fail_count++;
          end
        end
      end
      if (squeeze_req != squeeze_seen) begin
        squeeze_seen = squeeze_req;
        recv_hold = SQUEEZE_CYCLES;
      end
      if (recv_hold > 0) begin
        recv_hold--;
        out_stall <= 1'b1;
      end else if (recv_calm > 0) begin
        recv_calm--;
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 49) == 0) begin
        recv_calm = $urandom_range(20, 80);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 99) < 70) begin
        out_stall <= 1'b0;
      end else begin
        recv_hold = idle_len() - 1;
        out_stall <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    tick_count++;
    if (tick_count >= CYCLE_LIMIT) begin
      $display("heartbeat_lockup_watchdog test failed");
      $finish;
    end
  end

  function automatic void push_item(input logic c, input time_t t, input logic hb,
                                    input logic pg);
    pending_samples.push_back('{c, t, hb, pg});
  endfunction

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_POLL_INTERVAL:      live_cfg.poll_interval = val;
      CFG_EDGE_COUNT_TRIGGER: live_cfg.edge_count_trigger = val[TRIG_BITS-1:0];
      CFG_COOLDOWN_TIME:      live_cfg.cooldown_time = val;
      CFG_LOCKUP_TIME:        live_cfg.lockup_time = val;
      CFG_RECOVERY_ENABLE:    live_cfg.recovery_enable = val[0];
      default: ;
    endcase
  endtask

  task automatic apply_cfg(input cfg_t c);
    write_reg(CFG_POLL_INTERVAL, c.poll_interval);
    write_reg(CFG_EDGE_COUNT_TRIGGER, CFG_DATA_BITS'(c.edge_count_trigger));
    write_reg(CFG_COOLDOWN_TIME, c.cooldown_time);
    write_reg(CFG_LOCKUP_TIME, c.lockup_time);
    write_reg(CFG_RECOVERY_ENABLE, CFG_DATA_BITS'(c.recovery_enable));
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_samples.size() != 0 || in_valid || awaited_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic time_t next_time(input time_t t, input time_t iv);
    int    r;
    time_t unit;
    unit = (iv == 0 || iv > 100000) ? time_t'($urandom_range(1, 50)) : iv;
    r = $urandom_range(0, 99);
    if (r < 8) return t;
    if (r < 18) return t + $urandom_range(0, unit);
    if (r < 92) return t + unit + $urandom_range(0, 3);
    if (r < 97) return t + unit * $urandom_range(2, 40);
    return $urandom;
  endfunction

  // Sessions: a start then a run of timed samples, with some noise mixed in
  task automatic load_random(input int n);
    int    left;
    int    len;
    int    hb_pct;
    int    pg_low_pct;
    int    r;
    time_t t;
    logic  hb;
    left = n;
    while (left > 0) begin
      r = $urandom_range(0, 99);
      if (r < 30) t = $urandom_range(0, 1000);
      else if (r < 45) t = 32'hFFFF_FFFF - $urandom_range(0, 3000);
      else t = $urandom;
      case ($urandom_range(0, 3))
        0: hb_pct = 85;
        1: hb_pct = 3;
        2: hb_pct = 50;
        default: hb_pct = 0;
      endcase
      pg_low_pct = ($urandom_range(0, 4) == 0) ? 30 : 2;
      len = $urandom_range(5, 40);
      hb = 1'b0;
      // drop the start now and then to run on from the old state
      if ($urandom_range(0, 9) != 0) begin
        push_item(CMD_START, t, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        left--;
      end
      for (int k = 0; k < len && left > 0; k++) begin
        if ($urandom_range(0, 99) < 7) begin
          push_item(($urandom_range(0, 9) == 0) ? CMD_START : CMD_SAMPLE, $urandom,
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else begin
          t = next_time(t, live_cfg.poll_interval);
          if ($urandom_range(0, 99) < hb_pct) hb = ~hb;
          push_item(CMD_SAMPLE, t, hb, ($urandom_range(0, 99) < pg_low_pct) ? 1'b0 : 1'b1);
        end
        left--;
      end
    end
  endtask

  initial begin
    time_t t;
    live_cfg = '{RST_POLL_INTERVAL, RST_EDGE_COUNT_TRIGGER, RST_COOLDOWN_TIME,
                 RST_LOCKUP_TIME, RST_RECOVERY_ENABLE};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part on reset settings
    push_item(CMD_START, 32'hFFFF_FFFF, 1'b1, 1'b0);
    push_item(CMD_SAMPLE, 32'd0, 1'b0, 1'b1);       // skipped, below next poll
    push_item(CMD_SAMPLE, 32'd999, 1'b0, 1'b1);     // skipped, equal to next poll
    push_item(CMD_SAMPLE, 32'd1000, 1'b0, 1'b1);    // polled inside start cooldown
    push_item(CMD_SAMPLE, 32'd2000, 1'b0, 1'b0);    // power loss
    push_item(CMD_START, 32'd100000, 1'b0, 1'b1);
    push_item(CMD_SAMPLE, 32'd101001, 1'b0, 1'b1);  // stale heartbeat
    push_item(CMD_SAMPLE, 32'd102002, 1'b1, 1'b0);  // edge while power low
    push_item(CMD_SAMPLE, 32'd103003, 1'b1, 1'b0);  // power loss, no edge
    t = 32'd103003;
    // walk the edge count past the trigger to cut cooldown short
    for (int k = 0; k < 12; k++) begin
      t = t + 32'd1001;
      push_item(CMD_SAMPLE, t, k[0] ? 1'b1 : 1'b0, 1'b1);
    end
    push_item(CMD_SAMPLE, 32'hFFFF_FFFF, 1'b1, 1'b1);
    wait_idle();

    apply_cfg('{32'd10, 16'd3, 32'd200, 32'd50, 1'b1});
    load_random(130);
    wait_idle();

    apply_cfg('{32'd0, 16'd0, 32'd0, 32'd0, 1'b0});
    load_random(110);
    wait_idle();

    apply_cfg('{32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1});
    load_random(90);
    wait_idle();

    for (int p = 0; p < 3; p++) begin
      apply_cfg('{time_t'($urandom_range(1, 100)), trig_t'($urandom_range(0, 8)),
                  ($urandom_range(0, 3) == 0) ? time_t'($urandom)
                                              : time_t'($urandom_range(0, 2000)),
                  time_t'($urandom_range(1, 500)), 1'($urandom_range(0, 1))});
      load_random(130);
      // hold off the receiver so the block backs up into its input
      if (p == 1) squeeze_req++;
      wait_idle();
    end

    apply_cfg('{32'd25, 16'd1, 32'h8000_0000, 32'd100, 1'b0});
    load_random(100);
    wait_idle();

    apply_cfg('{RST_POLL_INTERVAL, RST_EDGE_COUNT_TRIGGER, RST_COOLDOWN_TIME,
                RST_LOCKUP_TIME, RST_RECOVERY_ENABLE});
    load_random(120);
    wait_idle();

    repeat (10) @(posedge clk);
    if (awaited_results.size() != 0) begin
      $error("%0d results never arrived", awaited_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("heartbeat_lockup_watchdog test passed");
    end else begin
      $display("heartbeat_lockup_watchdog test failed");
    end
    $finish;
  end

endmodule
